>>> src/bhe_pkg.sv
// Shared types, constants and shaper table builder for the bass harmonic exciter.
`timescale 1ns / 1ps

package bhe_pkg;

  localparam int SAMPLE_BITS          = 24;
  localparam int COEF_FRAC_BITS       = 30;
  localparam int SHAPER_TABLE_ENTRIES = 256;

  localparam int COEF_W    = 32;
  localparam int BLEND_W   = 16;
  localparam int ACC_W     = 64;
  localparam int SHAPE_W   = SAMPLE_BITS - 2;
  localparam int TBL_AW    = $clog2(SHAPER_TABLE_ENTRIES + 1);
  localparam int CFG_IDX_W = 3;

  localparam logic [BLEND_W-1:0] BLEND_RESET = 16'd10486;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_B0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_A1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_A2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_B0    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_A1    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_A2    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_GAIN = 3'd6;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]      coef_t;

  localparam sample_t SAMPLE_MAX = sample_t'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam sample_t SAMPLE_MIN = sample_t'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
    logic    block_start;
  } in_item_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
    logic    clipped;
  } out_item_t;

  typedef struct packed {
    coef_t              low_b0;
    coef_t              low_a1;
    coef_t              low_a2;
    coef_t              high_b0;
    coef_t              high_a1;
    coef_t              high_a2;
    logic [BLEND_W-1:0] blend_gain;
  } cfg_regs_t;

  typedef struct packed {
    logic start;
    logic clear_hist;
  } lane_cmd_t;

  typedef struct packed {
    logic    busy;
    logic    done;
    sample_t sample;
    logic    clip;
  } lane_res_t;

  // Restoring long division for the table builder; used at elaboration only.
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    int          b;
    quo = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One shaper table entry: tanh(4*i/N)/4 in sample units, built in Q30 from a
  // truncated Taylor series of e^-t squared four times. Evaluated at elaboration.
  function automatic logic [SHAPE_W-1:0] shape_entry(input int unsigned idx);
    logic [63:0] one;
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] e;
    logic [63:0] th;
    logic [63:0] r;
    int          k;
    int          q;
    int          sh;
    one  = 64'd1 << 30;
    sh   = 33 - SAMPLE_BITS;
    t    = (64'(idx) << 29) / SHAPER_TABLE_ENTRIES;
    term = one;
    pos  = one;
    neg  = 64'd0;
    for (k = 1; k <= 12; k++) begin
      term = div_u64((term * t) >> 30, 64'(k));
      if (k[0]) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    e = (pos > neg) ? (pos - neg) : 64'd0;
    if (e > one) begin
      e = one;
    end
    for (q = 0; q < 4; q++) begin
      e = (e * e) >> 30;
    end
    th = div_u64((one - e) << 30, one + e);
    r  = (th + (64'd1 << (sh - 1))) >> sh;
    return r[SHAPE_W-1:0];
  endfunction

endpackage

>>> src/bhe_lane.sv
// One channel lane: low-pass biquad, tanh table shaper, high-pass biquad and blend mix.
`timescale 1ns / 1ps

module bhe_lane import bhe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  lane_cmd_t cmd,
  input  sample_t   sample,
  input  cfg_regs_t cfg,
  input  logic      ack,
  output lane_res_t res
);

  localparam int STATE_W = 5;
  localparam int POS_W   = SAMPLE_BITS - 1 + TBL_AW;
  localparam int YW      = COEF_W + 1;

  localparam logic [STATE_W-1:0] ST_IDLE    = 5'd0;
  localparam logic [STATE_W-1:0] ST_LP_M0   = 5'd1;
  localparam logic [STATE_W-1:0] ST_LP_M1   = 5'd2;
  localparam logic [STATE_W-1:0] ST_LP_M1B  = 5'd3;
  localparam logic [STATE_W-1:0] ST_LP_M2   = 5'd4;
  localparam logic [STATE_W-1:0] ST_LP_M3   = 5'd5;
  localparam logic [STATE_W-1:0] ST_LP_M4   = 5'd6;
  localparam logic [STATE_W-1:0] ST_LP_ACC  = 5'd7;
  localparam logic [STATE_W-1:0] ST_LP_RND  = 5'd8;
  localparam logic [STATE_W-1:0] ST_LP_FIN  = 5'd9;
  localparam logic [STATE_W-1:0] ST_SH_ABS  = 5'd10;
  localparam logic [STATE_W-1:0] ST_SH_TBL  = 5'd11;
  localparam logic [STATE_W-1:0] ST_SH_MUL  = 5'd12;
  localparam logic [STATE_W-1:0] ST_SH_FIN  = 5'd13;
  localparam logic [STATE_W-1:0] ST_HP_M0   = 5'd14;
  localparam logic [STATE_W-1:0] ST_HP_M1   = 5'd15;
  localparam logic [STATE_W-1:0] ST_HP_M1B  = 5'd16;
  localparam logic [STATE_W-1:0] ST_HP_M2   = 5'd17;
  localparam logic [STATE_W-1:0] ST_HP_M3   = 5'd18;
  localparam logic [STATE_W-1:0] ST_HP_M4   = 5'd19;
  localparam logic [STATE_W-1:0] ST_HP_ACC  = 5'd20;
  localparam logic [STATE_W-1:0] ST_HP_RND  = 5'd21;
  localparam logic [STATE_W-1:0] ST_HP_FIN  = 5'd22;
  localparam logic [STATE_W-1:0] ST_MIX_MUL = 5'd23;
  localparam logic [STATE_W-1:0] ST_MIX_RND = 5'd24;
  localparam logic [STATE_W-1:0] ST_MIX_SUM = 5'd25;
  localparam logic [STATE_W-1:0] ST_DONE    = 5'd26;

  localparam logic [2:0] ACC_NONE = 3'd0;
  localparam logic [2:0] ACC_LOAD = 3'd1;
  localparam logic [2:0] ACC_ADD  = 3'd2;
  localparam logic [2:0] ACC_SUB  = 3'd3;
  localparam logic [2:0] ACC_RND  = 3'd4;

  localparam logic signed [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] MIX_HALF = ACC_W'(1) << (BLEND_W - 1);
  localparam coef_t COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
  localparam logic [TBL_AW-1:0] TBL_LAST = TBL_AW'(SHAPER_TABLE_ENTRIES);

  logic [STATE_W-1:0] state_r, state_nxt;

  sample_t x_r;
  sample_t lx1_r, lx2_r;
  coef_t   ly1_r, ly2_r;
  sample_t hx1_r, hx2_r;
  coef_t   hy1_r, hy2_r;
  sample_t sh_r;
  sample_t res_sample_r;
  logic    res_clip_r;

  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] prod_r;

  logic [SAMPLE_BITS-1:0]   abs_r;
  logic                     neg_r;
  logic [SHAPE_W-1:0]       tlo_r;
  logic [SHAPE_W-1:0]       d_r;
  logic [SAMPLE_BITS-2:0]   frac_r;
  coef_t                    mix_r;

  coef_t                   mul_a, mul_b;
  logic signed [ACC_W-1:0] mul_a_w, mul_b_w;
  logic [2:0]              acc_op;

  logic signed [ACC_W-1:0] addend;
  logic signed [ACC_W:0]   sum_w;
  logic signed [ACC_W-1:0] sat_sum;
  logic signed [ACC_W-1:0] q_full;
  logic [ACC_W-COEF_W:0]   q_hi;
  coef_t                   fin_val;

  logic [COEF_W-1:0]      abs_full;
  logic [SAMPLE_BITS-1:0] abs_clamp;
  logic [POS_W-1:0]       pos;
  logic [TBL_AW-1:0]      idx;
  logic [TBL_AW-1:0]      idx_hi;
  logic [SHAPE_W-1:0]     t_lo, t_hi, t_base, t_diff;
  logic [SHAPE_W-1:0]     shape_mag;
  sample_t                shape_val;

  logic signed [ACC_W-1:0] mix_sum;
  logic signed [YW-1:0]    y_sum;
  logic [YW-SAMPLE_BITS:0] y_hi;
  logic                    y_ovf;

  logic [SHAPE_W-1:0] shape_tbl [0:SHAPER_TABLE_ENTRIES];

  for (genvar gi = 0; gi <= SHAPER_TABLE_ENTRIES; gi++) begin : g_tbl
    localparam logic [SHAPE_W-1:0] ENTRY = shape_entry(gi);
    assign shape_tbl[gi] = ENTRY;
  end

  // Operand select and accumulate op for each step
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    acc_op = ACC_NONE;
    unique case (state_r)
      ST_LP_M0: begin
        mul_a = cfg.low_b0;
        mul_b = COEF_W'(x_r);
      end
      ST_LP_M1: begin
        mul_a  = cfg.low_b0;
        mul_b  = COEF_W'(lx1_r);
        acc_op = ACC_LOAD;
      end
      ST_LP_M1B: begin
        mul_a  = cfg.low_b0;
        mul_b  = COEF_W'(lx1_r);
        acc_op = ACC_ADD;
      end
      ST_LP_M2: begin
        mul_a  = cfg.low_b0;
        mul_b  = COEF_W'(lx2_r);
        acc_op = ACC_ADD;
      end
      ST_LP_M3: begin
        mul_a  = cfg.low_a1;
        mul_b  = ly1_r;
        acc_op = ACC_ADD;
      end
      ST_LP_M4: begin
        mul_a  = cfg.low_a2;
        mul_b  = ly2_r;
        acc_op = ACC_SUB;
      end
      ST_LP_ACC: acc_op = ACC_SUB;
      ST_LP_RND: acc_op = ACC_RND;
      ST_SH_MUL: begin
        mul_a = COEF_W'(d_r);
        mul_b = COEF_W'(frac_r);
      end
      ST_HP_M0: begin
        mul_a = cfg.high_b0;
        mul_b = COEF_W'(sh_r);
      end
      ST_HP_M1: begin
        mul_a  = cfg.high_b0;
        mul_b  = COEF_W'(hx1_r);
        acc_op = ACC_LOAD;
      end
      ST_HP_M1B: begin
        mul_a  = cfg.high_b0;
        mul_b  = COEF_W'(hx1_r);
        acc_op = ACC_SUB;
      end
      ST_HP_M2: begin
        mul_a  = cfg.high_b0;
        mul_b  = COEF_W'(hx2_r);
        acc_op = ACC_SUB;
      end
      ST_HP_M3: begin
        mul_a  = cfg.high_a1;
        mul_b  = hy1_r;
        acc_op = ACC_ADD;
      end
      ST_HP_M4: begin
        mul_a  = cfg.high_a2;
        mul_b  = hy2_r;
        acc_op = ACC_SUB;
      end
      ST_HP_ACC: acc_op = ACC_SUB;
      ST_HP_RND: acc_op = ACC_RND;
      ST_MIX_MUL: begin
        mul_a = COEF_W'(cfg.blend_gain);
        mul_b = hy1_r;
      end
      default: ;
    endcase
  end

  assign mul_a_w = ACC_W'(mul_a);
  assign mul_b_w = ACC_W'(mul_b);

  // Saturating accumulate at the signed 64-bit limits
  always_comb begin
    unique case (acc_op)
      ACC_ADD: addend = prod_r;
      ACC_SUB: addend = -prod_r;
      ACC_RND: addend = ACC_HALF;
      default: addend = '0;
    endcase
    sum_w = {acc_r[ACC_W-1], acc_r} + {addend[ACC_W-1], addend};
    if (sum_w[ACC_W] != sum_w[ACC_W-1]) begin
      sat_sum = sum_w[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_sum = sum_w[ACC_W-1:0];
    end
  end

  // Floor shift out the coefficient fraction, clamp to 32 bits
  always_comb begin
    q_full = acc_r >>> COEF_FRAC_BITS;
    q_hi   = q_full[ACC_W-1:COEF_W-1];
    if ((&q_hi) || !(|q_hi)) begin
      fin_val = q_full[COEF_W-1:0];
    end else begin
      fin_val = q_full[ACC_W-1] ? COEF_MIN : COEF_MAX;
    end
  end

  // Shaper: magnitude, table index and interpolation
  always_comb begin
    abs_full  = ly1_r[COEF_W-1] ? COEF_W'(-ly1_r) : COEF_W'(ly1_r);
    abs_clamp = (abs_full > COEF_W'(FULL_SCALE)) ? FULL_SCALE : abs_full[SAMPLE_BITS-1:0];
    pos       = POS_W'(abs_r) * POS_W'(SHAPER_TABLE_ENTRIES);
    idx       = pos[POS_W-1 -: TBL_AW];
    idx_hi    = (idx >= TBL_LAST) ? TBL_LAST : idx + TBL_AW'(1);
    t_lo      = shape_tbl[idx];
    t_hi      = shape_tbl[idx_hi];
    if (idx >= TBL_LAST) begin
      t_base = shape_tbl[TBL_LAST];
      t_diff = '0;
    end else begin
      t_base = t_lo;
      t_diff = (t_hi >= t_lo) ? (t_hi - t_lo) : '0;
    end
    shape_mag = tlo_r + prod_r[SHAPE_W+SAMPLE_BITS-2 : SAMPLE_BITS-1];
    shape_val = neg_r ? -sample_t'(shape_mag) : sample_t'(shape_mag);
  end

  // Blend mix and output saturation
  always_comb begin
    mix_sum = prod_r + MIX_HALF;
    y_sum   = YW'(x_r) + YW'(mix_r);
    y_hi    = y_sum[YW-1:SAMPLE_BITS-1];
    y_ovf   = !((&y_hi) || !(|y_hi));
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE: state_nxt = cmd.start ? ST_LP_M0 : ST_IDLE;
      ST_DONE: state_nxt = ack ? ST_IDLE : ST_DONE;
      default: state_nxt = state_r + STATE_W'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Filter histories: cleared by reset or by a block start mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lx1_r <= '0;
      lx2_r <= '0;
      ly1_r <= '0;
      ly2_r <= '0;
      hx1_r <= '0;
      hx2_r <= '0;
      hy1_r <= '0;
      hy2_r <= '0;
    end else if (state_r == ST_IDLE && cmd.start && cmd.clear_hist) begin
      lx1_r <= '0;
      lx2_r <= '0;
      ly1_r <= '0;
      ly2_r <= '0;
      hx1_r <= '0;
      hx2_r <= '0;
      hy1_r <= '0;
      hy2_r <= '0;
    end else if (state_r == ST_LP_FIN) begin
      lx2_r <= lx1_r;
      lx1_r <= x_r;
      ly2_r <= ly1_r;
      ly1_r <= fin_val;
    end else if (state_r == ST_HP_FIN) begin
      hx2_r <= hx1_r;
      hx1_r <= sh_r;
      hy2_r <= hy1_r;
      hy1_r <= fin_val;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a_w * mul_b_w;
    if (acc_op == ACC_LOAD) begin
      acc_r <= prod_r;
    end else if (acc_op != ACC_NONE) begin
      acc_r <= sat_sum;
    end
    if (state_r == ST_IDLE && cmd.start) begin
      x_r <= sample;
    end
    if (state_r == ST_SH_ABS) begin
      abs_r <= abs_clamp;
      neg_r <= ly1_r[COEF_W-1];
    end
    if (state_r == ST_SH_TBL) begin
      tlo_r  <= t_base;
      d_r    <= t_diff;
      frac_r <= pos[SAMPLE_BITS-2:0];
    end
    if (state_r == ST_SH_FIN) begin
      sh_r <= shape_val;
    end
    if (state_r == ST_MIX_RND) begin
      mix_r <= mix_sum[BLEND_W+COEF_W-1:BLEND_W];
    end
    if (state_r == ST_MIX_SUM) begin
      res_clip_r <= y_ovf;
      if (y_ovf) begin
        res_sample_r <= y_sum[YW-1] ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
        res_sample_r <= y_sum[SAMPLE_BITS-1:0];
      end
    end
  end

  assign res.busy   = (state_r != ST_IDLE);
  assign res.done   = (state_r == ST_DONE);
  assign res.sample = res_sample_r;
  assign res.clip   = res_clip_r;

endmodule

>>> src/bhe_merge.sv
// Merge stage: joins the two lane results into one output item behind a register.
`timescale 1ns / 1ps

module bhe_merge import bhe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  lane_res_t res_left,
  input  lane_res_t res_right,
  output logic      ack,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      out_valid_r;
  out_item_t out_data_r;

  // Take both lanes once the output slot is free or draining this cycle
  assign ack = res_left.done && res_right.done && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ack) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      out_data_r.left_out  <= res_left.sample;
      out_data_r.right_out <= res_right.sample;
      out_data_r.clipped   <= res_left.clip | res_right.clip;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/bass_harmonic_exciter_core.sv
// Top level of the stereo bass harmonic exciter: config registers, two lanes, merge stage.
`timescale 1ns / 1ps

//  channel  | ports                                  | moves
//  ---------+----------------------------------------+-----------------------------------
//  input    | in_valid, in_ready, in_data            | one stereo frame + block start
//  result   | out_valid, out_ready, out_data         | two saturated samples + clip flag
//  config   | cfg_valid, cfg_ready, cfg_index/data   | one register write, always taken
//
// Between two accepted items each lane runs 25 steps, where one 32x32 multiplier per
// lane runs 14 products in series, then waits in the done state until the merge stage
// takes the results, and returns to idle, where the next item is taken.
// Reset (synchronous, active low) clears filter histories, zeroes the coefficients and
// loads the default blend gain. A stalled output holds its item in the merge register;
// the lanes hold finished results and the next item waits until they are taken.

module bass_harmonic_exciter_core import bhe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  cfg_regs_t cfg_r;
  lane_cmd_t lane_cmd;
  lane_res_t res_left, res_right;
  logic      lane_ack;
  logic      in_accept;

  // Config writes are registered; indexes past the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_b0     <= '0;
      cfg_r.low_a1     <= '0;
      cfg_r.low_a2     <= '0;
      cfg_r.high_b0    <= '0;
      cfg_r.high_a1    <= '0;
      cfg_r.high_a2    <= '0;
      cfg_r.blend_gain <= BLEND_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LOW_B0:     cfg_r.low_b0     <= cfg_data;
        CFG_LOW_A1:     cfg_r.low_a1     <= cfg_data;
        CFG_LOW_A2:     cfg_r.low_a2     <= cfg_data;
        CFG_HIGH_B0:    cfg_r.high_b0    <= cfg_data;
        CFG_HIGH_A1:    cfg_r.high_a1    <= cfg_data;
        CFG_HIGH_A2:    cfg_r.high_a2    <= cfg_data;
        CFG_BLEND_GAIN: cfg_r.blend_gain <= cfg_data[BLEND_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a new frame only when both lanes are idle; the merge register decouples
  // the output, so a waiting result does not block the next frame.
  assign in_ready  = !res_left.busy && !res_right.busy;
  assign in_accept = in_valid && in_ready;

  assign lane_cmd.start      = in_accept;
  assign lane_cmd.clear_hist = in_data.block_start;

  bhe_lane u_lane_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (lane_cmd),
    .sample (in_data.left_in),
    .cfg    (cfg_r),
    .ack    (lane_ack),
    .res    (res_left)
  );

  bhe_lane u_lane_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (lane_cmd),
    .sample (in_data.right_in),
    .cfg    (cfg_r),
    .ack    (lane_ack),
    .res    (res_right)
  );

  // Join the lanes: OR the clip flags, hold the item until taken
  bhe_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_left  (res_left),
    .res_right (res_right),
    .ack       (lane_ack),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Lanes run in lockstep from the same start
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (res_left.busy == res_right.busy) && (res_left.done == res_right.done))
    else $error("lanes out of step");

  // An accepted frame starts both lanes
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (res_left.busy && !res_left.done))
    else $error("accepted frame did not start lanes");

  // A clipped result carries a saturated sample on at least one side
  a_clip_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.clipped) |->
      (out_data.left_out == SAMPLE_MAX || out_data.left_out == SAMPLE_MIN ||
       out_data.right_out == SAMPLE_MAX || out_data.right_out == SAMPLE_MIN))
    else $error("clip flag without saturated sample");

  // Finished lanes are released only into a free output slot
  a_ack_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    lane_ack |-> (!out_valid || out_ready))
    else $error("lane result merged over a pending item");

endmodule

>>> sim/bass_harmonic_exciter_core_tb.sv
// Self-checking testbench for the stereo bass harmonic exciter core.
`timescale 1ns / 1ps

// Approach: an independent fixed-point predictor of both channels (low-pass biquad, tanh
// table shaper, high-pass biquad, blend and saturating mix) runs on every accepted frame
// and queues the expected output item. A receiver process with random stalls compares each
// output item field by field against the oldest queued frame. Named tests walk through
// reset defaults, a realistic filter set driven into clipping, saturating coefficients,
// zero blend, a stream with no idling, random coefficient sets and block-structured
// program material.
module bass_harmonic_exciter_core_tb;
  import bhe_pkg::*;

  localparam int  HALF_PERIOD  = 4;
  localparam int  STALL_LIMIT  = 2000;   // cycles with no item moving on any channel
  localparam int  DRAIN_CYCLES = 40;     // longer than one item turnaround

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam longint FULL_SCALE = 64'sd1 <<< (SAMPLE_BITS - 1);

  // Butterworth-form sets at 48 kHz: 2 kHz low-pass, 500 Hz high-pass, Q2.30
  localparam coef_t LP_B0 = 32'sd15464000;
  localparam coef_t LP_A1 = -32'sd1753430000;
  localparam coef_t LP_A2 = 32'sd741532000;
  localparam coef_t HP_B0 = 32'sd1025182000;
  localparam coef_t HP_A1 = -32'sd2048162000;
  localparam coef_t HP_A2 = 32'sd978820000;
  localparam coef_t COEF_TOP = 32'sh7FFF_FFFF;
  localparam coef_t COEF_BOT = 32'sh8000_0000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data = '0;

  // Predictor state: mirrored registers and two filter taps per channel
  longint lp_b0 = 0, lp_a1 = 0, lp_a2 = 0;
  longint hp_b0 = 0, hp_a1 = 0, hp_a2 = 0;
  longint blend = BLEND_RESET;
  longint lp_x [0:3] = '{default: 0};
  longint lp_y [0:3] = '{default: 0};
  longint hp_x [0:3] = '{default: 0};
  longint hp_y [0:3] = '{default: 0};
  longint unsigned tanh_lut [0:SHAPER_TABLE_ENTRIES];

  out_item_t expected_frames [$];
  int        fail_count = 0;
  int        idle_max = 6;
  int        stall_left = 0;
  int        quiet_cycles = 0;
  bit        frame_offered = 1'b0;

  bass_harmonic_exciter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Fill the shaper table: tanh(4i/N)/4 in sample units. e^-t comes from a truncated
  // Taylor sum, squared four times to reach e^-2u, then tanh = (1 - e) / (1 + e).
  initial begin : build_tanh_lut
    longint unsigned one_q30, t, term, pos, neg, e, th;
    one_q30 = 64'd1 << 30;
    for (int i = 0; i <= SHAPER_TABLE_ENTRIES; i++) begin
      t    = (64'(i) << 29) / SHAPER_TABLE_ENTRIES;
      term = one_q30;
      pos  = one_q30;
      neg  = 0;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * t) >> 30) / 64'(k);
        if (k % 2 == 1) begin
          neg += term;
        end else begin
          pos += term;
        end
      end
      e = (pos > neg) ? pos - neg : 64'd0;
      if (e > one_q30) begin
        e = one_q30;
      end
      repeat (4) e = (e * e) >> 30;
      th = ((one_q30 - e) << 30) / (one_q30 + e);
      // round to nearest on the way down to sample units over four
      tanh_lut[i] = (th + (64'd1 << (32 - SAMPLE_BITS))) >> (33 - SAMPLE_BITS);
    end
  end

  // Add two 64-bit terms, pinning the sum at the signed limits on overflow.
  function automatic longint sat_sum(input longint a, input longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? I64_MIN : I64_MAX;
    end
    return s;
  endfunction

  // One biquad output: b0*(x0 +/- 2x1 + x2) - a1*y1 - a2*y2, rounded, floored, pinned to 32 bits.
  function automatic longint biquad_out(input longint x0, x1, x2, y1, y2, b0, a1, a2,
                                        input bit highpass);
    longint acc;
    longint mid;
    acc = b0 * x0;
    mid = b0 * x1;
    if (highpass) begin
      mid = -mid;
    end
    acc = sat_sum(acc, mid);
    acc = sat_sum(acc, mid);
    acc = sat_sum(acc, b0 * x2);
    acc = sat_sum(acc, -(a1 * y1));
    acc = sat_sum(acc, -(a2 * y2));
    acc = sat_sum(acc, 64'sd1 <<< (COEF_FRAC_BITS - 1));
    acc = acc >>> COEF_FRAC_BITS;
    if (acc > I32_MAX) return I32_MAX;
    if (acc < I32_MIN) return I32_MIN;
    return acc;
  endfunction

  // Odd-symmetric table shaper with truncated linear interpolation; clamp past full scale.
  function automatic longint shaped(input longint v);
    longint unsigned mag, p, idx, frac, r, lo, hi, d;
    bit neg;
    neg = (v < 0);
    mag = neg ? -v : v;
    if (mag > FULL_SCALE) begin
      mag = FULL_SCALE;
    end
    p    = mag * SHAPER_TABLE_ENTRIES;
    idx  = p >> (SAMPLE_BITS - 1);
    frac = p & (FULL_SCALE - 1);
    if (idx >= SHAPER_TABLE_ENTRIES) begin
      r = tanh_lut[SHAPER_TABLE_ENTRIES];
    end else begin
      lo = tanh_lut[idx];
      hi = tanh_lut[idx + 1];
      d  = (hi >= lo) ? hi - lo : 64'd0;
      r  = lo + ((d * frac) >> (SAMPLE_BITS - 1));
    end
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // Run both channels of one frame through the predictor and advance its histories.
  function automatic out_item_t predict_frame(input in_item_t f);
    out_item_t res;
    longint    x, lo, sh, hp, y;
    int        b;
    res = '0;
    if (f.block_start) begin
      lp_x = '{default: 0};
      lp_y = '{default: 0};
      hp_x = '{default: 0};
      hp_y = '{default: 0};
    end
    for (int ch = 0; ch < 2; ch++) begin
      b  = 2 * ch;
      x  = (ch == 0) ? f.left_in : f.right_in;
      lo = biquad_out(x, lp_x[b], lp_x[b+1], lp_y[b], lp_y[b+1], lp_b0, lp_a1, lp_a2, 1'b0);
      lp_x[b+1] = lp_x[b];
      lp_x[b]   = x;
      lp_y[b+1] = lp_y[b];
      lp_y[b]   = lo;
      sh = shaped(lo);
      hp = biquad_out(sh, hp_x[b], hp_x[b+1], hp_y[b], hp_y[b+1], hp_b0, hp_a1, hp_a2, 1'b1);
      hp_x[b+1] = hp_x[b];
      hp_x[b]   = sh;
      hp_y[b+1] = hp_y[b];
      hp_y[b]   = hp;
      y = x + ((blend * hp + 64'sd32768) >>> 16);
      if (y > SAMPLE_MAX || y < SAMPLE_MIN) begin
        res.clipped = 1'b1;
      end
      if (y > SAMPLE_MAX) y = SAMPLE_MAX;
      if (y < SAMPLE_MIN) y = SAMPLE_MIN;
      if (ch == 0) begin
        res.left_out = sample_t'(y);
      end else begin
        res.right_out = sample_t'(y);
      end
    end
    return res;
  endfunction

  // Offer one frame after a random gap; hold it until taken, then queue its prediction.
  task automatic send_frame(input sample_t left, input sample_t right, input logic start);
    in_item_t f;
    int       gap;
    f.left_in     = left;
    f.right_in    = right;
    f.block_start = start;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      if (frame_offered) begin
        in_valid <= 1'b0;
        frame_offered = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    frame_offered = 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_frames.insert(expected_frames.size(), predict_frame(f));
  endtask

  // Drop the input and hold until every queued frame has come back.
  task automatic settle();
    if (frame_offered) begin
      in_valid <= 1'b0;
      frame_offered = 1'b0;
    end
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  // One register write; the predictor follows only once the write is taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LOW_B0:     lp_b0 = coef_t'(value);
      CFG_LOW_A1:     lp_a1 = coef_t'(value);
      CFG_LOW_A2:     lp_a2 = coef_t'(value);
      CFG_HIGH_B0:    hp_b0 = coef_t'(value);
      CFG_HIGH_A1:    hp_a1 = coef_t'(value);
      CFG_HIGH_A2:    hp_a2 = coef_t'(value);
      CFG_BLEND_GAIN: blend = value[BLEND_W-1:0];
      default: ;  // unmapped index: nothing changes
    endcase
  endtask

  // Program a full setting. Lead with a junk write to the unmapped index, which must be ignored.
  task automatic load_settings(input coef_t lb0, la1, la2, hb0, ha1, ha2,
                               input logic [COEF_W-1:0] blend_word);
    settle();
    write_reg(CFG_UNMAPPED, $urandom);
    write_reg(CFG_LOW_B0, lb0);
    write_reg(CFG_LOW_A1, la1);
    write_reg(CFG_LOW_A2, la2);
    write_reg(CFG_HIGH_B0, hb0);
    write_reg(CFG_HIGH_A1, ha1);
    write_reg(CFG_HIGH_A2, ha2);
    write_reg(CFG_BLEND_GAIN, blend_word);
    cfg_valid <= 1'b0;
  endtask

  // Sample source: 0 = anything, 1 = quiet, 2 = at or near the rails.
  function automatic sample_t draw_sample(input int style);
    int v;
    case (style)
      1: v = int'($urandom_range(0, 8191)) - 4096;
      2: begin
        v = int'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
          0: v = SAMPLE_MAX;
          1: v = SAMPLE_MIN;
          2: v = SAMPLE_MAX - v;
          default: v = SAMPLE_MIN + v;
        endcase
      end
      default: v = $urandom;
    endcase
    return sample_t'(v);
  endfunction

  // Random program material: blocks opened by a start mark, steady content style per block,
  // with the odd stray restart in the middle of a block.
  task automatic stream_frames(input int count);
    int   left_in_block;
    int   style;
    logic start;
    left_in_block = 0;
    style = 0;
    repeat (count) begin
      if (left_in_block == 0) begin
        left_in_block = $urandom_range(4, 48);
        style = $urandom_range(0, 2);
        start = 1'b1;
      end else begin
        start = ($urandom_range(0, 29) == 0);
      end
      left_in_block--;
      send_frame(draw_sample(style), draw_sample(style), start);
    end
  endtask

  // Reset values: zero coefficients keep both filters at zero, so output is the dry input.
  task automatic test_dry_path_defaults();
    send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
    send_frame('0, 24'sd1, 1'b0);
    send_frame(-24'sd1, '0, 1'b0);
    send_frame(24'sh2A5A5A, 24'sh55A5A5, 1'b0);
  endtask

  // Realistic filters at full blend: drive steps at the rails until the shaper saturates
  // and the mix clips, then restart a block with opposite polarity per channel.
  task automatic test_tone_clipping();
    load_settings(LP_B0, LP_A1, LP_A2, HP_B0, HP_A1, HP_A2, 32'h0000_FFFF);
    send_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    repeat (4) send_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    repeat (3) send_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
  endtask

  // Rail coefficients: accumulators and filter outputs must pin instead of wrapping.
  task automatic test_accumulator_saturation();
    load_settings(COEF_TOP, COEF_BOT, COEF_TOP, COEF_BOT, COEF_TOP, COEF_BOT, 32'hFFFF_FFFF);
    send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_frame('0, '0, 1'b0);
    load_settings(COEF_BOT, COEF_TOP, COEF_BOT, COEF_TOP, COEF_BOT, COEF_TOP, 32'h0001_0001);
    send_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    send_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
  endtask

  // Zero blend: the filters keep running but the output must stay dry.
  task automatic test_zero_blend();
    load_settings(LP_B0, LP_A1, LP_A2, HP_B0, HP_A1, HP_A2, {16'($urandom), 16'h0000});
    stream_frames(60);
  endtask

  // Back-to-back frames and an always-ready receiver.
  task automatic test_steady_stream();
    load_settings(LP_B0, LP_A1, LP_A2, HP_B0, HP_A1, HP_A2, $urandom);
    idle_max = 0;
    stream_frames(80);
    settle();
    idle_max = 6;
  endtask

  // Random coefficient sets, fully random and scaled down to keep some out of saturation.
  task automatic test_random_coefficients();
    repeat (2) begin
      load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      stream_frames(40);
    end
    repeat (2) begin
      load_settings(coef_t'($signed($urandom) >>> 6), coef_t'($signed($urandom) >>> 2),
                    coef_t'($signed($urandom) >>> 2), coef_t'($signed($urandom) >>> 2),
                    coef_t'($signed($urandom) >>> 2), coef_t'($signed($urandom) >>> 2),
                    $urandom);
      stream_frames(40);
    end
  endtask

  // Default-like blend on realistic filters; pause mid-way until the pipeline is empty.
  task automatic test_program_material();
    load_settings(LP_B0, LP_A1, LP_A2, HP_B0, HP_A1, HP_A2, {16'($urandom), BLEND_RESET});
    stream_frames(100);
    settle();
    stream_frames(100);
  endtask

  // Receiver: check each taken item against the oldest prediction, then stall at random.
  always @(posedge clk) begin : result_check
    out_item_t want;
    int        stall_draw;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        $error("output item with no frame outstanding: %h", out_data);
        fail_count++;
      end else begin
        want = expected_frames.pop_front();
        if (out_data.left_out !== want.left_out) begin
          $error("left_out: expected %0d, got %0d", want.left_out, out_data.left_out);
          fail_count++;
        end
        if (out_data.right_out !== want.right_out) begin
          $error("right_out: expected %0d, got %0d", want.right_out, out_data.right_out);
          fail_count++;
        end
        if (out_data.clipped !== want.clipped) begin
          $error("clipped: expected %0b, got %0b", want.clipped, out_data.clipped);
          fail_count++;
        end
      end
      stall_draw = $urandom_range(0, idle_max);
      out_ready  <= (stall_draw == 0);
      stall_left <= stall_draw;
    end else if (!out_ready) begin
      if (stall_left <= 1) begin
        out_ready <= 1'b1;
      end else begin
        stall_left <= stall_left - 1;
      end
    end
  end

  // Watchdog: end the run if no item moves on any channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_dry_path_defaults();
    test_tone_clipping();
    test_accumulator_saturation();
    test_zero_blend();
    test_steady_stream();
    test_random_coefficients();
    test_program_material();
    settle();
    // let any stray item surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
src/bhe_pkg.sv
src/bhe_lane.sv
src/bhe_merge.sv
src/bass_harmonic_exciter_core.sv
sim/bass_harmonic_exciter_core_tb.sv
